// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define PAR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define PAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/par_pkg.sv =====
package par_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned AdcW    = 12;
  localparam int unsigned FsW     = 16;
  localparam int unsigned MvW     = 16;
  localparam int unsigned PctW    = 7;
  localparam int unsigned FwW     = 8;
  localparam int unsigned ProdW   = AdcW + FsW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  // ADC code of full scale
  localparam logic [AdcW-1:0] AdcFull = 12'd4095;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHbIv    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRsIv    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLowPct  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFs      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFw      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBuzzer  = 3'd5;

  localparam logic [TimeW-1:0] HbIvReset   = 32'd86400000;
  localparam logic [TimeW-1:0] RsIvReset   = 32'd300000;
  localparam logic [PctW-1:0]  LowPctReset = 7'd20;
  localparam logic [FsW-1:0]   FsReset     = 16'd5190;
  localparam logic [FwW-1:0]   FwReset     = 8'd0;

  // battery curve knees
  localparam logic [MvW-1:0] MvFull = 16'd3400;
  localparam logic [MvW-1:0] Mv80   = 16'd3200;
  localparam logic [MvW-1:0] Mv50   = 16'd3000;
  localparam logic [MvW-1:0] Mv20   = 16'd2800;
  localparam logic [MvW-1:0] MvZero = 16'd2400;

  typedef enum logic [2:0] {
    EV_LIFTED    = 3'd1,
    EV_RETURNED  = 3'd2,
    EV_HEARTBEAT = 3'd3,
    EV_LOWBAT    = 3'd4
  } event_e;

  // one queued poll: up to two reports
  typedef struct packed {
    event_e          ev0;
    event_e          ev1;
    logic            two;
    logic            test_flag;
    logic            alert;
    logic            beep0;
    logic [PctW-1:0] pct;
  } par_entry_t;

  // piecewise curve; divisions by 10 and 20 as multiply by 205 and shift
  function automatic logic [PctW-1:0] pct_from_mv(logic [MvW-1:0] mv);
    logic [MvW-1:0]  d;
    logic [19:0]     p;
    logic [PctW-1:0] pct;
    d   = '0;
    p   = '0;
    pct = '0;
    priority if (mv >= MvFull) begin
      pct = 7'd100;
    end else if (mv >= Mv80) begin
      d   = mv - Mv80;
      p   = 20'(d[7:0]) * 20'd205;
      pct = 7'd80 + 7'(p >> 11);
    end else if (mv >= Mv50) begin
      d   = mv - Mv50;
      p   = 20'(d[7:0]) * 20'd615;
      pct = 7'd50 + 7'(p >> 12);
    end else if (mv >= Mv20) begin
      d   = mv - Mv20;
      p   = 20'(d[7:0]) * 20'd615;
      pct = 7'd20 + 7'(p >> 12);
    end else if (mv >= MvZero) begin
      d   = mv - MvZero;
      p   = 20'(d[8:0]) * 20'd205;
      pct = 7'(p >> 12);
    end else begin
      pct = '0;
    end
    return pct;
  endfunction

endpackage

// ===== rtl/par_meter.sv =====
// Battery percentage: multiply, divide by 4095, curve. Three stages.
module par_meter import par_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [AdcW-1:0] adc_i,
  input  logic [FsW-1:0]  fs_i,
  output logic [PctW-1:0] pct_o
);

  logic [ProdW-1:0] prod_q;
  logic [MvW-1:0]   mv_q, mv_d;
  logic [PctW-1:0]  pct_q;

  logic [ProdW:0]   t;
  logic [MvW-1:0]   q;
  logic [ProdW-1:0] qm, r;

  // x/4095 ~ (x + x>>12 + x>>24) >> 12, short by at most one
  always_comb begin
    t    = (ProdW+1)'(prod_q) + (ProdW+1)'(prod_q >> 12) + (ProdW+1)'(prod_q >> 24);
    q    = MvW'(t >> 12);
    qm   = (ProdW'(q) << 12) - ProdW'(q);
    r    = prod_q - qm;
    mv_d = q + MvW'(r >= ProdW'(AdcFull));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(adc_i) * ProdW'(fs_i);
      mv_q   <= mv_d;
      pct_q  <= pct_from_mv(mv_q);
    end
  end

  assign pct_o = pct_q;

endmodule

// ===== rtl/par_front.sv =====
// Poll intake, battery pipeline and report decision.
module par_front import par_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [TimeW-1:0] now_i,
  input  logic             present_i,
  input  logic             test_i,
  input  logic [AdcW-1:0]  adc_i,
  input  logic [TimeW-1:0] hb_iv_i,
  input  logic [TimeW-1:0] rs_iv_i,
  input  logic [PctW-1:0]  low_pct_i,
  input  logic [FsW-1:0]   fs_i,
  input  logic             buzzer_i,
  input  logic             full_i,
  output logic             push_o,
  output par_entry_t       entry_o
);

  logic [2:0]       v_q;
  logic [TimeW-1:0] now_q [3];
  logic [2:0]       pres_q, test_q;

  logic             started_q, alert_q, pend_q;
  logic [TimeW-1:0] hb_stamp_q, rs_stamp_q;

  logic             adv;
  logic [PctW-1:0]  pct;

  logic [TimeW-1:0] hb_iv, rs_iv, el_hb, el_rs;
  logic             hb_due, rs_due, trans_l, trans_r, a_has, has_rep, pend, beep;
  event_e           hb_ev, a_ev;

  par_meter u_meter (
    .clk_i (clk_i),
    .en_i  (adv),
    .adc_i (adc_i),
    .fs_i  (fs_i),
    .pct_o (pct)
  );

  always_comb begin
    hb_iv = (hb_iv_i == '0) ? TimeW'(1) : hb_iv_i;
    rs_iv = (rs_iv_i == '0) ? TimeW'(1) : rs_iv_i;
    el_hb = now_q[2] - hb_stamp_q;
    el_rs = now_q[2] - rs_stamp_q;
    // power-up always sends a plain heartbeat
    hb_ev = (started_q && pct <= low_pct_i) ? EV_LOWBAT : EV_HEARTBEAT;
    if (!started_q) begin
      // power-up poll
      trans_l = !pres_q[2];
      trans_r = 1'b0;
      rs_due  = 1'b0;
      hb_due  = 1'b1;
      pend    = pend_q;
      beep    = 1'b0;
    end else begin
      trans_l = !alert_q && !pres_q[2];
      trans_r = alert_q && pres_q[2];
      rs_due  = alert_q && !pres_q[2] && (el_rs >= rs_iv);
      hb_due  = el_hb >= hb_iv;
      pend    = pend_q || test_q[2];
      beep    = trans_l && buzzer_i;
    end
    a_has   = trans_l || trans_r || rs_due;
    a_ev    = trans_r ? EV_RETURNED : EV_LIFTED;
    has_rep = a_has || hb_due;

    entry_o.ev0       = a_has ? a_ev : hb_ev;
    entry_o.ev1       = hb_ev;
    entry_o.two       = a_has && hb_due;
    entry_o.test_flag = pend;
    entry_o.alert     = !pres_q[2];
    entry_o.beep0     = a_has && beep;
    entry_o.pct       = pct;
  end

  // whole pipe holds while a poll with reports faces a full queue
  assign adv     = !(v_q[2] && has_rep && full_i);
  assign ready_o = adv;
  assign push_o  = v_q[2] && adv && has_rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q        <= '0;
      started_q  <= 1'b0;
      alert_q    <= 1'b0;
      pend_q     <= 1'b0;
      hb_stamp_q <= '0;
      rs_stamp_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[1:0], valid_i};
      if (v_q[2]) begin
        started_q <= 1'b1;
        alert_q   <= !pres_q[2];
        pend_q    <= has_rep ? 1'b0 : pend;
        if (trans_l || rs_due) begin
          rs_stamp_q <= now_q[2];
        end
        if (hb_due) begin
          hb_stamp_q <= now_q[2];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      now_q[0] <= now_i;
      now_q[1] <= now_q[0];
      now_q[2] <= now_q[1];
      pres_q   <= {pres_q[1:0], present_i};
      test_q   <= {test_q[1:0], test_i};
    end
  end

endmodule

// ===== rtl/par_queue.sv =====
// Small FIFO of decided polls.
module par_queue import par_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  par_entry_t data_i,
  input  logic       pop_i,
  output par_entry_t data_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  par_entry_t      mem_q [DEPTH];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign data_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/par_back.sv =====
// Report sequencer: one or two beats per queued poll, registered output.
module par_back import par_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  par_entry_t      entry_i,
  input  logic            empty_i,
  output logic            pop_o,
  input  logic [FwW-1:0]  fw_i,
  output logic            valid_o,
  input  logic            ready_i,
  output event_e          ev_o,
  output logic [PctW-1:0] pct_o,
  output logic [FwW-1:0]  fw_o,
  output logic            test_flag_o,
  output logic            alert_o,
  output logic            beep_o,
  output logic            last_o
);

  logic            valid_q, phase_q, load;
  event_e          ev_q;
  logic [PctW-1:0] pct_q;
  logic [FwW-1:0]  fw_q;
  logic            tf_q, alert_q, beep_q, last_q;

  assign load  = !valid_q || ready_i;
  assign pop_o = load && !empty_i && (phase_q || !entry_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        phase_q <= !phase_q && entry_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      ev_q    <= phase_q ? entry_i.ev1 : entry_i.ev0;
      tf_q    <= !phase_q && entry_i.test_flag;
      beep_q  <= !phase_q && entry_i.beep0;
      last_q  <= phase_q || !entry_i.two;
      pct_q   <= entry_i.pct;
      alert_q <= entry_i.alert;
      fw_q    <= fw_i;
    end
  end

  assign valid_o     = valid_q;
  assign ev_o        = ev_q;
  assign pct_o       = pct_q;
  assign fw_o        = fw_q;
  assign test_flag_o = tf_q;
  assign alert_o     = alert_q;
  assign beep_o      = beep_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/presence_alert_reporter.sv =====
// Presence alert reporter. Each input beat is one poll (time, presence switch,
// test button, averaged battery reading); each output beat is one report, and a
// poll yields zero, one or two reports, the final one marked by tlast. A new
// poll is taken every cycle while the report queue has room; polls pass a
// three-register front (battery multiply, divide by 4095, percentage curve)
// whose last stage makes the state decision, and wait in a QUEUE_DEPTH-entry
// queue. The output side sends one report per cycle while the receiver is ready;
// the output sequencer sends a poll's two reports one after the other. The
// first report is offered once the poll has passed the front, the queue and the
// output register. Configuration is written through the plain cfg port and
// must be changed only while no poll is in flight.
module presence_alert_reporter import par_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // poll stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [47:0]        s_axis_tdata,   // now_ms, sign_present, test_pressed, battery_adc
  // report stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,   // battery_pct, fw_byte, test_flag, alert_active, beep
  output logic [2:0]         m_axis_tuser,   // event_code
  output logic               m_axis_tlast,
  // register writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  // configuration registers
  logic [TimeW-1:0] hb_iv_q, rs_iv_q;
  logic [PctW-1:0]  low_pct_q;
  logic [FsW-1:0]   fs_q;
  logic [FwW-1:0]   fw_q;
  logic             buzzer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_iv_q   <= HbIvReset;
      rs_iv_q   <= RsIvReset;
      low_pct_q <= LowPctReset;
      fs_q      <= FsReset;
      fw_q      <= FwReset;
      buzzer_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHbIv:   hb_iv_q   <= cfg_wdata_i;
        RegRsIv:   rs_iv_q   <= cfg_wdata_i;
        RegLowPct: low_pct_q <= cfg_wdata_i[PctW-1:0];
        RegFs:     fs_q      <= cfg_wdata_i[FsW-1:0];
        RegFw:     fw_q      <= cfg_wdata_i[FwW-1:0];
        RegBuzzer: buzzer_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // front -> queue -> back
  par_entry_t push_entry, head_entry;
  logic       push, pop, q_full, q_empty;

  event_e          ev;
  logic [PctW-1:0] pct;
  logic [FwW-1:0]  fw_byte;
  logic            test_flag, alert_active, beep;

  par_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .now_i     (s_axis_tdata[31:0]),
    .present_i (s_axis_tdata[32]),
    .test_i    (s_axis_tdata[33]),
    .adc_i     (s_axis_tdata[45:34]),
    .hb_iv_i   (hb_iv_q),
    .rs_iv_i   (rs_iv_q),
    .low_pct_i (low_pct_q),
    .fs_i      (fs_q),
    .buzzer_i  (buzzer_q),
    .full_i    (q_full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  par_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (head_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  par_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .fw_i        (fw_q),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .ev_o        (ev),
    .pct_o       (pct),
    .fw_o        (fw_byte),
    .test_flag_o (test_flag),
    .alert_o     (alert_active),
    .beep_o      (beep),
    .last_o      (m_axis_tlast)
  );

  // tdata bits 47:46 of the poll beat are padding and ignored
  assign m_axis_tdata = {6'b0, beep, alert_active, test_flag, fw_byte, pct};
  assign m_axis_tuser = ev;

endmodule

// ===== rtl/par_checker.sv =====
`include "assert_macros.svh"

// Port-level checks on the report stream.
module par_checker import par_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled beat holds
  `PAR_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // first of a pair is always a lifted or returned report
  `PAR_ASSERT_SAME(a_pair_head, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == EV_LIFTED || m_axis_tuser == EV_RETURNED)

  // beep only on a lifted report that leaves alert set
  `PAR_ASSERT_SAME(a_beep, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[17], m_axis_tuser == EV_LIFTED && m_axis_tdata[16])

  // a returned report always closes the alert
  `PAR_ASSERT_SAME(a_returned, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == EV_RETURNED, !m_axis_tdata[16])

endmodule

bind presence_alert_reporter par_checker u_par_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/presence_alert_checker.sv =====
// Watches the poll and report streams, predicts each poll's reports and
// compares them beat by beat. Tracks register writes on the cfg port.
module presence_alert_checker import par_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               poll_tvalid_i,
  input  logic               poll_tready_i,
  input  logic [47:0]        poll_tdata_i,   // now_ms, sign_present, test_pressed, battery_adc
  input  logic               rpt_tvalid_i,
  input  logic               rpt_tready_i,
  input  logic [23:0]        rpt_tdata_i,    // battery_pct, fw_byte, test_flag, alert_active, beep
  input  logic [2:0]         rpt_tuser_i,    // event_code
  input  logic               rpt_tlast_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output int                 fail_count_o,
  output int                 outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    event_e          ev;
    logic [PctW-1:0] pct;
    logic [FwW-1:0]  fw;
    logic            test_flag;
    logic            alert;
    logic            beep;
    logic            last;
  } report_t;

  // register copies
  logic [TimeW-1:0] hb_iv_ms;
  logic [TimeW-1:0] rs_iv_ms;
  logic [PctW-1:0]  low_pct;
  logic [FsW-1:0]   fs_mv;
  logic [FwW-1:0]   fw_byte;
  logic             buzzer_on;

  // sign state
  logic             started;
  logic             alert;
  logic [TimeW-1:0] hb_stamp;
  logic [TimeW-1:0] rs_stamp;
  logic             test_latched;

  report_t pending_reports[$];
  report_t poll_reports[$];

  function automatic logic [PctW-1:0] curve_pct(int unsigned mv);
    if (mv >= MvFull) return PctW'(100);
    if (mv >= Mv80)   return PctW'(80 + (mv - Mv80) * 20 / 200);
    if (mv >= Mv50)   return PctW'(50 + (mv - Mv50) * 30 / 200);
    if (mv >= Mv20)   return PctW'(20 + (mv - Mv20) * 30 / 200);
    if (mv >= MvZero) return PctW'((mv - MvZero) * 20 / 400);
    return '0;
  endfunction

  // each report carries the latched test press once
  function automatic void stage_report(event_e ev, logic [PctW-1:0] pct, logic beep);
    report_t r;
    r.ev        = ev;
    r.pct       = pct;
    r.fw        = fw_byte;
    r.test_flag = test_latched;
    r.alert     = 1'b0;
    r.beep      = beep;
    r.last      = 1'b0;
    test_latched = 1'b0;
    poll_reports.push_back(r);
  endfunction

  function automatic void predict_poll(logic [TimeW-1:0] now, logic present, logic test,
                                       logic [AdcW-1:0] adc);
    int unsigned      mv;
    logic [PctW-1:0]  pct;
    logic [TimeW-1:0] hb_iv;
    logic [TimeW-1:0] rs_iv;
    mv    = 32'(adc) * 32'(fs_mv) / 32'(AdcFull);
    pct   = curve_pct(mv);
    hb_iv = (hb_iv_ms == '0) ? TimeW'(1) : hb_iv_ms;
    rs_iv = (rs_iv_ms == '0) ? TimeW'(1) : rs_iv_ms;
    poll_reports.delete();
    if (!started) begin
      // power-up: button ignored, no beep
      started = 1'b1;
      alert   = !present;
      if (alert) begin
        stage_report(EV_LIFTED, pct, 1'b0);
        rs_stamp = now;
      end
      stage_report(EV_HEARTBEAT, pct, 1'b0);
      hb_stamp = now;
    end else begin
      if (test) test_latched = 1'b1;
      if (!alert && !present) begin
        alert = 1'b1;
        stage_report(EV_LIFTED, pct, buzzer_on);
        rs_stamp = now;
      end else if (alert && present) begin
        alert = 1'b0;
        stage_report(EV_RETURNED, pct, 1'b0);
      end
      if (alert && (now - rs_stamp) >= rs_iv) begin
        stage_report(EV_LIFTED, pct, 1'b0);
        rs_stamp = now;
      end
      if ((now - hb_stamp) >= hb_iv) begin
        stage_report((pct <= low_pct) ? EV_LOWBAT : EV_HEARTBEAT, pct, 1'b0);
        hb_stamp = now;
      end
    end
    foreach (poll_reports[k]) begin
      poll_reports[k].alert = alert;
      poll_reports[k].last  = (k == poll_reports.size() - 1);
      pending_reports.push_back(poll_reports[k]);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_iv_ms      = HbIvReset;
      rs_iv_ms      = RsIvReset;
      low_pct       = LowPctReset;
      fs_mv         = FsReset;
      fw_byte       = FwReset;
      buzzer_on     = 1'b0;
      started       = 1'b0;
      alert         = 1'b0;
      hb_stamp      = '0;
      rs_stamp      = '0;
      test_latched  = 1'b0;
      pending_reports.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegHbIv:   hb_iv_ms  = cfg_wdata_i[TimeW-1:0];
          RegRsIv:   rs_iv_ms  = cfg_wdata_i[TimeW-1:0];
          RegLowPct: low_pct   = cfg_wdata_i[PctW-1:0];
          RegFs:     fs_mv     = cfg_wdata_i[FsW-1:0];
          RegFw:     fw_byte   = cfg_wdata_i[FwW-1:0];
          RegBuzzer: buzzer_on = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (rpt_tvalid_i && rpt_tready_i) begin
        if (pending_reports.size() == 0) begin
          $error("report beat with no poll awaiting it");
          fail_count_o++;
        end else begin
          report_t want;
          want = pending_reports.pop_front();
          check_field("event_code",   want.ev,        rpt_tuser_i);
          check_field("battery_pct",  want.pct,       rpt_tdata_i[6:0]);
          check_field("fw_byte",      want.fw,        rpt_tdata_i[14:7]);
          check_field("test_flag",    want.test_flag, rpt_tdata_i[15]);
          check_field("alert_active", want.alert,     rpt_tdata_i[16]);
          check_field("beep",         want.beep,      rpt_tdata_i[17]);
          check_field("last",         want.last,      rpt_tlast_i);
        end
      end
      if (poll_tvalid_i && poll_tready_i)
        predict_poll(poll_tdata_i[31:0], poll_tdata_i[32], poll_tdata_i[33],
                     poll_tdata_i[45:34]);
      outstanding_o = pending_reports.size();
    end
  end

endmodule

// ===== tb/tb_presence_alert_reporter.sv =====
// Stimulus and verdict for the presence alert reporter. The checker beside
// the block does all prediction and comparison.
module tb_presence_alert_reporter import par_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 16;   // > poll-to-report latency, covers no-report polls
  localparam int HoldCycles  = 300;  // long receiver hold-off
  localparam int HoldPolls   = 30;   // polls offered during the hold, enough to fill the queue

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata  = '0;  // now_ms, sign_present, test_pressed, battery_adc
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;        // battery_pct, fw_byte, test_flag, alert_active, beep
  logic [2:0]         m_axis_tuser;        // event_code
  logic               m_axis_tlast;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgW-1:0]    cfg_wdata_i   = '0;

  int fail_count;
  int outstanding;

  // receiver hold-off request, picked up by the receiver process
  logic hold_req = 1'b0;

  // stimulus context
  logic [TimeW-1:0] clock_ms;
  logic             present_now;
  int unsigned      step_ms;
  int unsigned      cur_fs;

  always #2 clk_i = ~clk_i;

  presence_alert_reporter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  presence_alert_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .poll_tvalid_i (s_axis_tvalid),
    .poll_tready_i (s_axis_tready),
    .poll_tdata_i  (s_axis_tdata),
    .rpt_tvalid_i  (m_axis_tvalid),
    .rpt_tready_i  (m_axis_tready),
    .rpt_tdata_i   (m_axis_tdata),
    .rpt_tuser_i   (m_axis_tuser),
    .rpt_tlast_i   (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Hard stop, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: alternating ready/stall runs, mostly short stalls, a few long
  // ones, some long stretches of steady ready. A hold request overrides all.
  initial begin : receiver
    int  run_left;
    int  hold_left;
    int  r;
    logic level;
    run_left  = 0;
    hold_left = 0;
    level     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          level = !level;
          r     = $urandom_range(0, 99);
          if (level)
            run_left = (r < 80) ? $urandom_range(1, 20) : $urandom_range(30, 80);
          else if (r < 80)
            run_left = $urandom_range(1, 3);
          else if (r < 95)
            run_left = $urandom_range(4, 10);
          else
            run_left = $urandom_range(30, 64);
        end
        run_left--;
        m_axis_tready <= level;
      end
    end
  end

  // One register write per cycle; caller drops the enable after the batch.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_setting(logic [31:0] hb, logic [31:0] rs, int unsigned low,
                                 int unsigned fs, int unsigned fw, logic buz);
    write_reg(RegHbIv,   hb);
    write_reg(RegRsIv,   rs);
    write_reg(RegLowPct, CfgW'(low));
    write_reg(RegFs,     CfgW'(fs));
    write_reg(RegFw,     CfgW'(fw));
    write_reg(RegBuzzer, CfgW'(buz));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_fs = fs;
  endtask

  // Sender stops, all reports drain, then a margin for polls that report nothing.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offer one poll and hold it until accepted; tvalid is left high.
  task automatic send_poll(logic [31:0] now, logic present, logic test, logic [11:0] adc);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, adc, test, present, now};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 45)      gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else             gap = $urandom_range(20, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random poll: time mostly walks forward around the phase step, sometimes
  // stands still or jumps anywhere; presence flips now and then; battery
  // reading lands on the curve half the time.
  task automatic send_random_poll();
    int          r;
    int unsigned lo;
    int unsigned hi;
    logic [11:0] adc;
    r = $urandom_range(0, 99);
    if (r < 4)
      clock_ms = $urandom();
    else if (r >= 8)
      clock_ms = clock_ms + $urandom_range(0, 2 * step_ms);
    if ($urandom_range(0, 99) < 20) present_now = !present_now;
    adc = 12'($urandom_range(0, 4095));
    if (cur_fs != 0 && $urandom_range(0, 1) == 1) begin
      lo = 2300 * 4095 / cur_fs;
      hi = 3500 * 4095 / cur_fs;
      if (hi > 4095) hi = 4095;
      if (lo <= hi) adc = 12'($urandom_range(lo, hi));
    end
    send_poll(clock_ms, present_now, $urandom_range(0, 99) < 15, adc);
  endtask

  task automatic run_phase(logic [31:0] hb, logic [31:0] rs, int unsigned low,
                           int unsigned fs, int unsigned fw, logic buz,
                           int unsigned step, int polls);
    quiesce();
    program_setting(hb, rs, low, fs, fw, buz);
    step_ms = (step > (1 << 30)) ? (1 << 30) : step;
    for (int i = 0; i < polls; i++) begin
      send_random_poll();
      idle_sender();
    end
  endtask

  initial begin : stimulus
    logic [31:0] hb;
    logic [31:0] rs;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed ----
    // buzzer on before power-up: the power-up lifted report still must not beep
    program_setting(32'd1000, 32'd300, 20, 5190, 8'hA5, 1'b1);
    // power-up with the sign gone: lifted then heartbeat, button ignored
    send_poll(32'hFFFF_FF00, 1'b0, 1'b1, 12'd0);
    idle_sender();
    // still gone, interval not reached: nothing
    send_poll(32'hFFFF_FF10, 1'b0, 1'b0, 12'd4095);
    idle_sender();
    // button latched on a poll that reports nothing
    send_poll(32'hFFFF_FF20, 1'b0, 1'b1, 12'd2000);
    idle_sender();
    // time wraps; sign back: returned carries the latched test press
    send_poll(32'h0000_0010, 1'b1, 1'b0, 12'd3000);
    idle_sender();
    // lifted transition with beep
    send_poll(32'h0000_0020, 1'b0, 1'b0, 12'd2500);
    idle_sender();
    // resend interval reached exactly: resend without beep
    send_poll(32'h0000_014C, 1'b0, 1'b0, 12'd2600);
    idle_sender();
    // resend and heartbeat on one poll
    send_poll(32'd1000, 1'b0, 1'b0, 12'd4095);
    idle_sender();
    // returned plus low battery
    send_poll(32'd2000, 1'b1, 1'b0, 12'd1800);
    idle_sender();
    send_poll(32'd2000, 1'b1, 1'b1, 12'd1800);
    quiesce();
    // smallest nonzero intervals
    program_setting(32'd1, 32'd1, 100, 5190, 8'hFF, 1'b0);
    send_poll(32'd0, 1'b1, 1'b1, 12'd3100);
    quiesce();
    // largest intervals: fire only when elapsed time is all ones
    program_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 5190, 8'h00, 1'b1);
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b0, 12'd4095);
    idle_sender();
    send_poll(32'hFFFF_FFFE, 1'b1, 1'b0, 12'd0);
    quiesce();
    // zero intervals behave as one
    program_setting(32'd0, 32'd0, 50, 5190, 8'h5A, 1'b1);
    send_poll(32'd5, 1'b0, 1'b0, 12'd2300);
    idle_sender();
    send_poll(32'd6, 1'b0, 1'b1, 12'd2300);
    idle_sender();
    send_poll(32'd6, 1'b0, 1'b0, 12'd2300);
    quiesce();
    // full scale 4095 makes millivolts equal the code: walk the curve knees
    program_setting(32'd0, 32'd0, 20, 4095, 8'h3C, 1'b0);
    send_poll(32'd7,  1'b1, 1'b0, 12'd3400);
    idle_sender();
    send_poll(32'd8,  1'b1, 1'b0, 12'd3399);
    idle_sender();
    send_poll(32'd9,  1'b1, 1'b0, 12'd3200);
    idle_sender();
    send_poll(32'd10, 1'b1, 1'b0, 12'd3000);
    idle_sender();
    send_poll(32'd11, 1'b1, 1'b0, 12'd2800);
    idle_sender();
    send_poll(32'd12, 1'b1, 1'b0, 12'd2400);
    idle_sender();
    send_poll(32'd13, 1'b1, 1'b0, 12'd2399);
    clock_ms    = 32'd13;
    present_now = 1'b1;

    // ---- random phases ----
    run_phase(32'd1000, 32'd300, 20, 5190, 8'h21, 1'b1, 150, 75);
    // block fills while the receiver holds off
    hold_req = 1'b1;
    for (int i = 0; i < HoldPolls; i++) send_random_poll();
    // a report on every poll whenever time moves, two when the sign is also gone or changes; always low battery
    run_phase(32'd0, 32'd0, 100, 65535, 8'hFF, 1'b0, 2, 75);
    // only transitions report; zero full scale gives zero percent
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 8'h00, 1'b1, 1000, 75);
    for (int p = 0; p < 4; p++) begin
      hb = $urandom_range(1, 5000);
      rs = $urandom_range(1, 2000);
      run_phase(hb, rs, $urandom_range(0, 100),
                ($urandom_range(0, 1) == 1) ? $urandom_range(4000, 6500)
                                            : $urandom_range(0, 65535),
                $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                ((hb < rs) ? hb : rs) / 2 + 1, 75);
    end
    // back to the reset values
    run_phase(HbIvReset, RsIvReset, LowPctReset, FsReset, FwReset, 1'b0, 60000, 75);

    quiesce();
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/par_pkg.sv
rtl/par_meter.sv
rtl/par_front.sv
rtl/par_queue.sv
rtl/par_back.sv
rtl/presence_alert_reporter.sv
rtl/par_checker.sv
tb/presence_alert_checker.sv
tb/tb_presence_alert_reporter.sv
